// File: rtl/thrs_pkg.sv
// Shared types, constants and register indexes for the tap/hold radial selector.
package thrs_pkg;

    localparam int COORD_BITS    = 16;
    localparam int MAG_BITS      = COORD_BITS;
    localparam int KEY_BITS      = 8;
    localparam int HOLD_BITS     = 16;
    localparam int RAD_BITS      = 15;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam int SECTOR_BITS   = 3;

    // tan(22.5 deg) in Q16
    localparam int FRAC_BITS = 16;
    localparam int TAN_BITS  = 15;
    localparam logic [TAN_BITS-1:0] TAN_22_5_Q16 = 15'd27146;

    localparam int CMP_BITS = MAG_BITS + FRAC_BITS;
    localparam int SQ_BITS  = (2 * MAG_BITS + 1 > 2 * RAD_BITS) ? 2 * MAG_BITS + 1 : 2 * RAD_BITS;

    localparam logic [CFG_IDX_BITS-1:0] CFG_TARGET_KEY  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD_TICKS  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEAD_ZONE   = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HOOK_ENABLE = 2'd3;

    localparam logic [KEY_BITS-1:0]  RST_TARGET_KEY = 8'd173;
    localparam logic [HOLD_BITS-1:0] RST_HOLD_TICKS = 16'd150;
    localparam logic [RAD_BITS-1:0]  RST_DEAD_ZONE  = 15'd60;

    localparam logic [SECTOR_BITS-1:0] SEC_UP         = 3'd0;
    localparam logic [SECTOR_BITS-1:0] SEC_UP_RIGHT   = 3'd1;
    localparam logic [SECTOR_BITS-1:0] SEC_RIGHT      = 3'd2;
    localparam logic [SECTOR_BITS-1:0] SEC_DOWN_RIGHT = 3'd3;
    localparam logic [SECTOR_BITS-1:0] SEC_DOWN       = 3'd4;
    localparam logic [SECTOR_BITS-1:0] SEC_DOWN_LEFT  = 3'd5;
    localparam logic [SECTOR_BITS-1:0] SEC_LEFT       = 3'd6;
    localparam logic [SECTOR_BITS-1:0] SEC_UP_LEFT    = 3'd7;

    typedef enum logic [2:0] {
        ACT_PASS    = 3'd0,
        ACT_SWALLOW = 3'd1,
        ACT_TAP     = 3'd2,
        ACT_SECTOR  = 3'd3,
        ACT_OPENED  = 3'd4,
        ACT_EMPTY   = 3'd5
    } t_action;

    typedef struct packed {
        logic                         operation;
        logic                         hook_action;
        logic [KEY_BITS-1:0]          key_code;
        logic                         key_down;
        logic                         injected;
        logic signed [COORD_BITS-1:0] cursor_x;
        logic signed [COORD_BITS-1:0] cursor_y;
        logic signed [COORD_BITS-1:0] center_x;
        logic signed [COORD_BITS-1:0] center_y;
    } t_in_word;

    typedef struct packed {
        t_action                action;
        logic [SECTOR_BITS-1:0] sector;
        logic                   menu_visible;
    } t_out_word;

    typedef struct packed {
        logic [KEY_BITS-1:0]  target_key;
        logic [HOLD_BITS-1:0] hold_ticks;
        logic [RAD_BITS-1:0]  dead_zone_radius;
        logic                 hook_enable;
    } t_cfg;

    // Classified item on its way to the sector stages
    typedef struct packed {
        t_action             action;
        logic                menu_visible;
        logic [MAG_BITS-1:0] ax;
        logic [MAG_BITS-1:0] ay;
        logic                dx_pos;
        logic                dy_pos;
        logic                dy_neg;
    } t_cls_word;

endpackage

// File: rtl/thrs_ctrl.sv
// Hotkey state (held flag, menu flag, hold count) and per-word classification stage.
module thrs_ctrl import thrs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_word  i_word,
    output logic      o_ready,
    input  t_cfg      i_cfg,
    input  logic      i_cfg_clear,
    output logic      o_valid,
    output t_cls_word o_word,
    input  logic      i_ready
);

    logic                 r_key_held, n_key_held;
    logic                 r_menu_open, n_menu_open;
    logic [HOLD_BITS-1:0] r_hold_count, n_hold_count;
    logic                 r_valid;
    t_cls_word            r_word, n_word;

    logic                  load;
    logic                  hit;
    logic [HOLD_BITS-1:0]  cnt_inc;
    logic signed [COORD_BITS:0] dx, dy;

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    assign hit = i_cfg.hook_enable && i_word.hook_action && !i_word.injected &&
                 (i_word.key_code == i_cfg.target_key);

    assign cnt_inc = (r_hold_count == {HOLD_BITS{1'b1}}) ? r_hold_count
                                                         : r_hold_count + 1'b1;

    assign dx = {i_word.cursor_x[COORD_BITS-1], i_word.cursor_x}
              - {i_word.center_x[COORD_BITS-1], i_word.center_x};
    assign dy = {i_word.center_y[COORD_BITS-1], i_word.center_y}
              - {i_word.cursor_y[COORD_BITS-1], i_word.cursor_y};

    always_comb begin
        n_key_held   = r_key_held;
        n_menu_open  = r_menu_open;
        n_hold_count = r_hold_count;
        n_word       = '0;
        n_word.action = ACT_PASS;

        if (i_word.operation) begin
            if (i_cfg.hook_enable && r_key_held && !r_menu_open) begin
                n_hold_count = cnt_inc;
                if (cnt_inc >= i_cfg.hold_ticks) begin
                    n_menu_open   = 1'b1;
                    n_word.action = ACT_OPENED;
                end
            end
        end else if (hit) begin
            if (i_word.key_down) begin
                if (!r_key_held) begin
                    n_key_held   = 1'b1;
                    n_hold_count = '0;
                end
                n_word.action = ACT_SWALLOW;
            end else begin
                n_key_held   = 1'b0;
                n_hold_count = '0;
                if (r_menu_open) begin
                    n_menu_open   = 1'b0;
                    n_word.action = ACT_SECTOR;   // may turn into ACT_EMPTY later
                end else begin
                    n_word.action = ACT_TAP;
                end
            end
        end

        n_word.menu_visible = n_menu_open;
        n_word.ax     = dx[COORD_BITS] ? MAG_BITS'(-dx) : MAG_BITS'(dx);
        n_word.ay     = dy[COORD_BITS] ? MAG_BITS'(-dy) : MAG_BITS'(dy);
        n_word.dx_pos = !dx[COORD_BITS] && (dx != '0);
        n_word.dy_pos = !dy[COORD_BITS] && (dy != '0);
        n_word.dy_neg = dy[COORD_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_held   <= 1'b0;
            r_menu_open  <= 1'b0;
            r_hold_count <= '0;
            r_valid      <= 1'b0;
        end else begin
            if (i_cfg_clear) begin
                r_key_held   <= 1'b0;
                r_menu_open  <= 1'b0;
                r_hold_count <= '0;
            end else if (load) begin
                r_key_held   <= n_key_held;
                r_menu_open  <= n_menu_open;
                r_hold_count <= n_hold_count;
            end
            if (o_ready) begin
                r_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// File: rtl/thrs_sector.sv
// Squares and tangent products, then dead-zone test and sector pick into the result register.
module thrs_sector import thrs_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  t_cls_word           i_word,
    output logic                o_ready,
    input  logic [RAD_BITS-1:0] i_radius,
    output logic                o_valid,
    output t_out_word           o_word,
    input  logic                i_stall
);

    // product stage
    logic                      r_p_valid;
    t_cls_word                 r_p_word;
    logic [2*MAG_BITS-1:0]     r_sq_x, r_sq_y, n_sq_x, n_sq_y;
    logic [2*RAD_BITS-1:0]     r_sq_r, n_sq_r;
    logic [MAG_BITS+TAN_BITS-1:0] r_ax_t, r_ay_t, n_ax_t, n_ay_t;
    logic                      p_ready;
    logic                      p_load;

    // result stage
    logic                      r_valid;
    t_out_word                 r_word, n_word;
    logic                      o_load;
    logic [SQ_BITS-1:0]        dist_sq;
    logic                      outside;
    logic                      near_vert, near_horz;

    assign o_load  = !r_valid || !i_stall;
    assign p_ready = o_load;
    assign o_ready = !r_p_valid || p_ready;
    assign p_load  = i_valid && o_ready;

    assign n_sq_x = i_word.ax * i_word.ax;
    assign n_sq_y = i_word.ay * i_word.ay;
    assign n_sq_r = i_radius * i_radius;
    assign n_ax_t = i_word.ax * TAN_22_5_Q16;
    assign n_ay_t = i_word.ay * TAN_22_5_Q16;

    always_ff @(posedge i_clk) begin
        if (p_load) begin
            r_p_word <= i_word;
            r_sq_x   <= n_sq_x;
            r_sq_y   <= n_sq_y;
            r_sq_r   <= n_sq_r;
            r_ax_t   <= n_ax_t;
            r_ay_t   <= n_ay_t;
        end
    end

    assign dist_sq   = SQ_BITS'(r_sq_x) + SQ_BITS'(r_sq_y);
    assign outside   = dist_sq >= SQ_BITS'(r_sq_r);
    assign near_vert = {r_p_word.ax, {FRAC_BITS{1'b0}}} < CMP_BITS'(r_ay_t);
    assign near_horz = {r_p_word.ay, {FRAC_BITS{1'b0}}} < CMP_BITS'(r_ax_t);

    always_comb begin
        n_word              = '0;
        n_word.action       = r_p_word.action;
        n_word.menu_visible = r_p_word.menu_visible;
        if (r_p_word.action == ACT_SECTOR) begin
            if (!outside) begin
                n_word.action = ACT_EMPTY;
            end else if (r_p_word.ax == '0 && r_p_word.ay == '0) begin
                n_word.sector = SEC_UP;
            end else if (near_vert) begin
                n_word.sector = r_p_word.dy_pos ? SEC_UP : SEC_DOWN;
            end else if (near_horz) begin
                n_word.sector = r_p_word.dx_pos ? SEC_RIGHT : SEC_LEFT;
            end else if (r_p_word.dx_pos) begin
                n_word.sector = r_p_word.dy_pos ? SEC_UP_RIGHT : SEC_DOWN_RIGHT;
            end else begin
                n_word.sector = r_p_word.dy_neg ? SEC_DOWN_LEFT : SEC_UP_LEFT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            if (o_ready) begin
                r_p_valid <= i_valid;
            end
            if (o_load) begin
                r_valid <= r_p_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load && r_p_valid) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// File: rtl/tap_hold_radial_selector_top.sv
// Top level of the tap/hold radial selector: config registers, input register, stage hookup.
//
//  Channel | Direction | Handshake            | Word
//  --------+-----------+----------------------+-------------------------------
//  in      | to block  | i_valid / o_stall    | i_word  (t_in_word)
//  out     | from block| o_valid / i_stall    | o_word  (t_out_word)
//  config  | to block  | i_cfg_we             | i_cfg_idx, i_cfg_data
//
// One word per cycle sustained while i_stall is low; a result is registered in turn in the
// input register (at acceptance), then the classification, product and result registers.
// Hold state updates as a word leaves the input register, so back-to-back words
// see each other's effect. Stalls collapse bubbles stage by stage.
// Reset is synchronous; o_stall is high during reset, config returns to its defaults
// and all valid flags and the hotkey state clear.
module tap_hold_radial_selector_top import thrs_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  t_in_word                 i_word,
    output logic                     o_valid,
    input  logic                     i_stall,
    output t_out_word                o_word,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    t_cfg      r_cfg;
    logic      cfg_clear;
    logic      r_in_valid;
    t_in_word  r_in_word;
    logic      in_ready;
    logic      ctrl_ready;
    logic      cls_valid;
    t_cls_word cls_word;
    logic      sec_ready;

    assign cfg_clear = i_cfg_we && (i_cfg_idx == CFG_HOOK_ENABLE) && !i_cfg_data[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_key       <= RST_TARGET_KEY;
            r_cfg.hold_ticks       <= RST_HOLD_TICKS;
            r_cfg.dead_zone_radius <= RST_DEAD_ZONE;
            r_cfg.hook_enable      <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TARGET_KEY:  r_cfg.target_key       <= i_cfg_data[KEY_BITS-1:0];
                CFG_HOLD_TICKS:  r_cfg.hold_ticks       <= i_cfg_data[HOLD_BITS-1:0];
                CFG_DEAD_ZONE:   r_cfg.dead_zone_radius <= i_cfg_data[RAD_BITS-1:0];
                CFG_HOOK_ENABLE: r_cfg.hook_enable      <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign in_ready = !r_in_valid || ctrl_ready;
    assign o_stall  = !in_ready || !i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_valid) begin
            r_in_word <= i_word;
        end
    end

    thrs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_in_valid),
        .i_word      (r_in_word),
        .o_ready     (ctrl_ready),
        .i_cfg       (r_cfg),
        .i_cfg_clear (cfg_clear),
        .o_valid     (cls_valid),
        .o_word      (cls_word),
        .i_ready     (sec_ready)
    );

    thrs_sector u_sector (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (cls_valid),
        .i_word   (cls_word),
        .o_ready  (sec_ready),
        .i_radius (r_cfg.dead_zone_radius),
        .o_valid  (o_valid),
        .o_word   (o_word),
        .i_stall  (i_stall)
    );

endmodule
